// File: rtl/iisq_pkg.sv
// ============================================================================
// iisq_pkg
// Shared widths, types and helpers for the integral image block.
// ============================================================================
`default_nettype none

package iisq_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int DIM_W      = 11;
    localparam int IDX_W      = 10;
    localparam int ROW_SUM_W  = 18;
    localparam int ROW_SQ_W   = 26;
    localparam int AREA_W     = 28;
    localparam int AREA_SQ_W  = 36;
    localparam int SQUARE_W   = 2 * PIXEL_BITS;
    localparam int LINE_W     = AREA_W + AREA_SQ_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // One result word as it leaves the pipeline.
    typedef struct packed {
        logic                  frame_end;
        logic [AREA_SQ_W-1:0]  area_sq_sum;
        logic [AREA_W-1:0]     area_sum;
        logic [IDX_W-1:0]      row_index;
        logic [IDX_W-1:0]      column;
    } result_t;

    // Clamps a dimension register to 1..maxv.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/integral_image_sum_and_squares_top.sv
// Path: a result word is registered in the second stage, then in the result
// queue. Throughput: one pixel per cycle while the result queue has room;
// the line store takes one read and one write per pixel and a four-word
// result queue absorbs output stalls. Reset (aresetn, synchronous, active
// low) returns the counters to the frame origin and the dimensions to
// 1024 x 1024; the line store is not cleared: a frame's first row ignores it.
// ============================================================================
// integral_image_sum_and_squares_top
// Streaming integral image with squared sums over a configurable frame.
// ============================================================================
`default_nettype none

module integral_image_sum_and_squares_top (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire [iisq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire [iisq_pkg::DIM_W-1:0]       cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [7:0]                       s_tdata,   // [7:0] pixel
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [9:0] column, [19:10] row_index, [47:20] area_sum, [83:48] area_sq_sum
    output logic [87:0]                     m_tdata,
    output logic                            m_tlast    // frame_end
);

    logic              in_accept;
    logic              busy;
    logic              res_valid;
    iisq_pkg::result_t res_word;
    iisq_pkg::result_t out_word;
    logic [2:0]        fill;
    logic              pop;

    // Room must remain for the word still in the pipeline.
    assign s_tready  = ({1'b0, fill} + {3'b000, busy}) < 4'd4;
    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    iisq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_pixel  (s_tdata[iisq_pkg::PIXEL_BITS-1:0]),
        .busy      (busy),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    iisq_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_word (res_word),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .fill      (fill)
    );

    assign m_tdata = {4'b0000, out_word.area_sq_sum, out_word.area_sum,
                      out_word.row_index, out_word.column};
    assign m_tlast = out_word.frame_end;

endmodule

`default_nettype wire

// File: rtl/iisq_ram.sv
// ============================================================================
// iisq_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ============================================================================
`default_nettype none

module iisq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/iisq_core.sv
// ============================================================================
// iisq_core
// Raster counters, line store and the two-stage read-add-write pipeline.
// ============================================================================
`default_nettype none

module iisq_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [iisq_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire [iisq_pkg::DIM_W-1:0]         cfg_data,
    input  wire                               in_accept,
    input  wire [iisq_pkg::PIXEL_BITS-1:0]    in_pixel,
    output logic                              busy,
    output logic                              res_valid,
    output iisq_pkg::result_t                 res_word
);

    localparam logic [iisq_pkg::DIM_W-1:0] MAX_W = iisq_pkg::DIM_W'(iisq_pkg::MAX_WIDTH);
    localparam logic [iisq_pkg::DIM_W-1:0] MAX_H = iisq_pkg::DIM_W'(iisq_pkg::MAX_HEIGHT);

    logic [iisq_pkg::DIM_W-1:0]      frame_width_reg;
    logic [iisq_pkg::DIM_W-1:0]      frame_height_reg;
    logic [iisq_pkg::IDX_W-1:0]      col_count_reg, col_count_next;
    logic [iisq_pkg::IDX_W-1:0]      row_count_reg, row_count_next;
    logic [iisq_pkg::DIM_W-1:0]      w_eff, h_eff;
    logic                            last_col, last_row;

    // Second stage.
    logic                            s1_valid_reg;
    logic [iisq_pkg::PIXEL_BITS-1:0] s1_pixel_reg;
    logic [iisq_pkg::IDX_W-1:0]      s1_col_reg;
    logic [iisq_pkg::IDX_W-1:0]      s1_row_reg;
    logic                            s1_frame_end_reg;
    logic                            s1_fwd_reg;
    logic [iisq_pkg::AREA_W-1:0]     s1_fwd_sum_reg;
    logic [iisq_pkg::AREA_SQ_W-1:0]  s1_fwd_sq_reg;

    logic [iisq_pkg::ROW_SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [iisq_pkg::ROW_SQ_W-1:0]   row_sq_reg, row_sq_next;
    logic [iisq_pkg::SQUARE_W-1:0]   square;
    logic [iisq_pkg::LINE_W-1:0]     line_rd;
    logic [iisq_pkg::AREA_W-1:0]     above_sum, area_sum;
    logic [iisq_pkg::AREA_SQ_W-1:0]  above_sq, area_sq;
    logic                            fwd_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= MAX_W;
            frame_height_reg <= MAX_H;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                iisq_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                iisq_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff    = iisq_pkg::clamp_dim(frame_width_reg, MAX_W);
    assign h_eff    = iisq_pkg::clamp_dim(frame_height_reg, MAX_H);
    assign last_col = ({1'b0, col_count_reg} + iisq_pkg::DIM_W'(1)) >= w_eff;
    assign last_row = ({1'b0, row_count_reg} + iisq_pkg::DIM_W'(1)) >= h_eff;

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept) begin
            if (last_col) begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + iisq_pkg::IDX_W'(1);
            end else begin
                col_count_next = col_count_reg + iisq_pkg::IDX_W'(1);
            end
        end
    end

    // The word in the second stage writes the same entry that is read now
    // (a one-pixel-wide frame), so its result is passed along directly.
    assign fwd_hit = s1_valid_reg && (s1_col_reg == col_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            row_sum_reg   <= '0;
            row_sq_reg    <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= in_accept;
            row_sum_reg   <= row_sum_next;
            row_sq_reg    <= row_sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pixel_reg     <= in_pixel;
            s1_col_reg       <= col_count_reg;
            s1_row_reg       <= row_count_reg;
            s1_frame_end_reg <= last_col && last_row;
            s1_fwd_reg       <= fwd_hit;
            s1_fwd_sum_reg   <= area_sum;
            s1_fwd_sq_reg    <= area_sq;
        end
    end

    iisq_ram #(
        .WIDTH (iisq_pkg::LINE_W),
        .DEPTH (iisq_pkg::MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({area_sq, area_sum}),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (line_rd)
    );

    assign square = iisq_pkg::SQUARE_W'(s1_pixel_reg) * iisq_pkg::SQUARE_W'(s1_pixel_reg);

    always_comb begin
        row_sum_next = row_sum_reg;
        row_sq_next  = row_sq_reg;
        if (s1_valid_reg) begin
            if (s1_col_reg == '0) begin
                row_sum_next = iisq_pkg::ROW_SUM_W'(s1_pixel_reg);
                row_sq_next  = iisq_pkg::ROW_SQ_W'(square);
            end else begin
                row_sum_next = row_sum_reg + iisq_pkg::ROW_SUM_W'(s1_pixel_reg);
                row_sq_next  = row_sq_reg + iisq_pkg::ROW_SQ_W'(square);
            end
        end
    end

    always_comb begin
        if (s1_row_reg == '0) begin
            above_sum = '0;
            above_sq  = '0;
        end else if (s1_fwd_reg) begin
            above_sum = s1_fwd_sum_reg;
            above_sq  = s1_fwd_sq_reg;
        end else begin
            above_sum = line_rd[iisq_pkg::AREA_W-1:0];
            above_sq  = line_rd[iisq_pkg::LINE_W-1:iisq_pkg::AREA_W];
        end
        area_sum = iisq_pkg::AREA_W'(row_sum_next) + above_sum;
        area_sq  = iisq_pkg::AREA_SQ_W'(row_sq_next) + above_sq;
    end

    assign busy                 = s1_valid_reg;
    assign res_valid            = s1_valid_reg;
    assign res_word.frame_end   = s1_frame_end_reg;
    assign res_word.area_sq_sum = area_sq;
    assign res_word.area_sum    = area_sum;
    assign res_word.row_index   = s1_row_reg;
    assign res_word.column      = s1_col_reg;

endmodule

`default_nettype wire

// File: rtl/iisq_outq.sv
// ============================================================================
// iisq_outq
// Four-word result queue that decouples the pipeline from the output stall.
// ============================================================================
`default_nettype none

module iisq_outq (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire iisq_pkg::result_t push_word,
    input  wire                 pop,
    output logic                out_valid,
    output iisq_pkg::result_t   out_word,
    output logic [2:0]          fill
);

    iisq_pkg::result_t entry [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg, fill_next;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 3'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= push_word;
        end
    end

    assign out_valid = (fill_reg != '0);
    assign out_word  = entry[rd_ptr_reg];
    assign fill      = fill_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: integral image with squared sums
// Feeds grayscale pixels in raster order through several frame sizes and
// compares every result word, field by field, against an integral image
// computed alongside. A short scripted run with hand-worked answers comes
// first, then random pixels under three idling patterns and a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import iisq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int PIXELS_PER_MODE = 100;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [DIM_W-1:0]     value;
        bit                   typed;
        result_t              want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [87:0]          m_tdata;
    logic                 m_tlast;

    // Integral image tracked alongside the block.
    logic [DIM_W-1:0]     width_reg  = 11'd1024;
    logic [DIM_W-1:0]     height_reg = 11'd1024;
    logic [IDX_W-1:0]     col_at     = '0;
    logic [IDX_W-1:0]     row_at     = '0;
    logic [ROW_SUM_W-1:0] run_sum    = '0;
    logic [ROW_SQ_W-1:0]  run_sq     = '0;
    logic [AREA_W-1:0]    line_sum [MAX_WIDTH];
    logic [AREA_SQ_W-1:0] line_sq  [MAX_WIDTH];

    result_t   pending_sums[$];
    plan_row_t scripted[$];

    int feed_idle_pct  = 0;
    int drain_idle_pct = 0;
    int hold_reqs      = 0;
    int hold_served    = 0;
    int hold_cnt       = 0;
    int mismatches     = 0;
    int words_seen     = 0;
    int quiet_cycles   = 0;

    // Hand-worked rows cover the frame origin, a width cut short mid-row,
    // a zero height acting as one, a zero width, an oversized height and a
    // height cut short mid-frame. The last rows are checked by computation.
    plan_row_t plan [] = '{
        '{1'b0, REG_FRAME_WIDTH,  11'd255,  1'b1, '{1'b0, 36'd65025,  28'd255, 10'd0, 10'd0}},
        '{1'b0, REG_FRAME_WIDTH,  11'd0,    1'b1, '{1'b0, 36'd65025,  28'd255, 10'd0, 10'd1}},
        '{1'b0, REG_FRAME_WIDTH,  11'd1,    1'b1, '{1'b0, 36'd65026,  28'd256, 10'd0, 10'd2}},
        '{1'b1, REG_FRAME_WIDTH,  11'd2,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd128,  1'b1, '{1'b0, 36'd81410,  28'd384, 10'd0, 10'd3}},
        '{1'b0, REG_FRAME_WIDTH,  11'd10,   1'b1, '{1'b0, 36'd65125,  28'd265, 10'd1, 10'd0}},
        '{1'b1, REG_FRAME_HEIGHT, 11'd0,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd20,   1'b1, '{1'b1, 36'd65525,  28'd285, 10'd1, 10'd1}},
        '{1'b0, REG_FRAME_WIDTH,  11'd7,    1'b1, '{1'b0, 36'd49,     28'd7,   10'd0, 10'd0}},
        '{1'b0, REG_FRAME_WIDTH,  11'd255,  1'b1, '{1'b1, 36'd65074,  28'd262, 10'd0, 10'd1}},
        '{1'b1, REG_FRAME_WIDTH,  11'd0,    1'b0, '0},
        '{1'b1, REG_FRAME_HEIGHT, 11'd2047, 1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd255,  1'b1, '{1'b0, 36'd65025,  28'd255, 10'd0, 10'd0}},
        '{1'b0, REG_FRAME_WIDTH,  11'd255,  1'b1, '{1'b0, 36'd130050, 28'd510, 10'd1, 10'd0}},
        '{1'b0, REG_FRAME_WIDTH,  11'd0,    1'b1, '{1'b0, 36'd130050, 28'd510, 10'd2, 10'd0}},
        '{1'b1, REG_FRAME_HEIGHT, 11'd1,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd1,    1'b1, '{1'b1, 36'd130051, 28'd511, 10'd3, 10'd0}},
        '{1'b1, REG_FRAME_WIDTH,  11'd3,    1'b0, '0},
        '{1'b1, REG_FRAME_HEIGHT, 11'd2,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd255,  1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd0,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd128,  1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd1,    1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd254,  1'b0, '0},
        '{1'b0, REG_FRAME_WIDTH,  11'd127,  1'b0, '0}
    };

    integral_image_sum_and_squares_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] pixel
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [9:0] column, [19:10] row_index, [47:20] area_sum,
                                // [83:48] area_sq_sum
        .m_tlast  (m_tlast)     // frame_end
    );

    always #6 aclk = ~aclk;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int limit);
        if (v == '0) return DIM_W'(1);
        if (v > limit) return DIM_W'(limit);
        return v;
    endfunction

    function automatic logic [7:0] any_pixel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] any_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return DIM_W'($urandom_range(1024, 2047));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Adds one pixel to the running row sums and the line store and works
    // out the result word, then steps the raster counters.
    task automatic integrate_pixel(input logic [7:0] px, output result_t r);
        logic [DIM_W-1:0]     w_eff;
        logic [DIM_W-1:0]     h_eff;
        logic [15:0]          px_sq;
        logic [AREA_W-1:0]    above;
        logic [AREA_SQ_W-1:0] above_sq;
        logic                 last_col;
        logic                 last_row;
        w_eff = eff_dim(width_reg, MAX_WIDTH);
        h_eff = eff_dim(height_reg, MAX_HEIGHT);
        px_sq = 16'(px) * 16'(px);
        if (col_at == '0) begin
            run_sum = '0;
            run_sq  = '0;
        end
        run_sum  = run_sum + ROW_SUM_W'(px);
        run_sq   = run_sq + ROW_SQ_W'(px_sq);
        above    = (row_at != '0) ? line_sum[col_at] : '0;
        above_sq = (row_at != '0) ? line_sq[col_at] : '0;
        r.area_sum    = AREA_W'(run_sum) + above;
        r.area_sq_sum = AREA_SQ_W'(run_sq) + above_sq;
        line_sum[col_at] = r.area_sum;
        line_sq[col_at]  = r.area_sq_sum;
        last_col = ({1'b0, col_at} + 11'd1) >= w_eff;
        last_row = ({1'b0, row_at} + 11'd1) >= h_eff;
        r.column    = col_at;
        r.row_index = row_at;
        r.frame_end = last_col && last_row;
        if (last_col) begin
            col_at = '0;
            row_at = last_row ? '0 : row_at + IDX_W'(1);
        end else begin
            col_at = col_at + IDX_W'(1);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt  = hold_cnt - 1;
        end else if (hold_served != hold_reqs) begin
            hold_served = hold_served + 1;
            hold_cnt    = HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    always @(posedge aclk) begin : watch
        result_t   want;
        result_t   got;
        plan_row_t row;
        if (!aresetn) begin
            width_reg    = 11'd1024;
            height_reg   = 11'd1024;
            col_at       = '0;
            row_at       = '0;
            run_sum      = '0;
            run_sq       = '0;
            quiet_cycles = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_FRAME_WIDTH) begin
                    width_reg = cfg_data;
                end else begin
                    height_reg = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                integrate_pixel(s_tdata, want);
                if (scripted.size() != 0) begin
                    row = scripted.pop_front();
                    if (row.typed) want = row.want;
                end
                pending_sums.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.column      = m_tdata[9:0];
                got.row_index   = m_tdata[19:10];
                got.area_sum    = m_tdata[47:20];
                got.area_sq_sum = m_tdata[83:48];
                got.frame_end   = m_tlast;
                if (pending_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("word %0d arrived with nothing expected", words_seen);
                end else begin
                    want = pending_sums.pop_front();
                    if (want.column !== got.column || want.row_index !== got.row_index
                            || want.area_sum !== got.area_sum
                            || want.area_sq_sum !== got.area_sq_sum
                            || want.frame_end !== got.frame_end) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("word %0d expected col %0d row %0d sum %0d sq %0d end %0b",
                                     words_seen, want.column, want.row_index, want.area_sum,
                                     want.area_sq_sum, want.frame_end);
                            $display("word %0d received col %0d row %0d sum %0d sq %0d end %0b",
                                     words_seen, got.column, got.row_index, got.area_sum,
                                     got.area_sq_sum, got.frame_end);
                        end
                    end
                end
                words_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Leaves s_tvalid high after the word is taken, so back-to-back pixels
    // never lower and raise it in the same step.
    task automatic push_pixel(input logic [7:0] px);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic retune(input logic [DIM_W-1:0] w_new, input logic [DIM_W-1:0] h_new);
        logic [DIM_W-1:0] w_now;
        int               n;
        s_tvalid <= 1'b0;
        wait_drained();
        // Below the first row the line store is only written up to the
        // current width, so a wider frame has to start at the origin. A
        // height of one closes the open frame at the end of this row.
        w_now = eff_dim(width_reg, MAX_WIDTH);
        if (row_at != '0 && eff_dim(w_new, MAX_WIDTH) > w_now) begin
            write_reg(REG_FRAME_HEIGHT, 11'd1);
            n = (({1'b0, col_at} + 11'd1) >= w_now) ? 1 : int'(w_now) - int'(col_at);
            repeat (n) push_pixel(any_pixel());
            s_tvalid <= 1'b0;
            wait_drained();
        end
        write_reg(REG_FRAME_WIDTH, w_new);
        write_reg(REG_FRAME_HEIGHT, h_new);
    endtask

    initial begin
        int sent;
        int n;
        foreach (plan[i]) begin
            if (!plan[i].is_cfg) scripted.push_back(plan[i]);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                push_pixel(plan[i].value[7:0]);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin feed_idle_pct = 20; drain_idle_pct = 81; end
                1: begin feed_idle_pct = 81; drain_idle_pct = 20; end
                default: begin feed_idle_pct = 0; drain_idle_pct = 0; end
            endcase
            if (mode == 2) begin
                // An oversized width cut off mid-row, then a one-column
                // frame fed back to back.
                retune(11'd2047, 11'd1);
                repeat (40) push_pixel(any_pixel());
                retune(11'd0, 11'd1024);
                repeat (40) push_pixel(any_pixel());
                retune(11'd5, 11'd4);
                // Output held off while pixels keep coming, so the block
                // fills up and pushes back on its input.
                hold_reqs = hold_reqs + 1;
                repeat (40) push_pixel(any_pixel());
            end
            sent = 0;
            while (sent < PIXELS_PER_MODE) begin
                retune(any_dim(), any_dim());
                n = $urandom_range(1, 50);
                repeat (n) push_pixel(any_pixel());
                sent += n;
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
